// ===== rtl/shp3x3_pkg.sv =====
package shp3x3_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_MAX_CHANNELS = 4;

    // Fixed field widths
    localparam int DIM_W    = 13;
    localparam int NCH_W    = 3;
    localparam int SAMPLE_W = 8;

    // Output queue depth
    localparam int OUT_DEPTH = 3;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    localparam logic [DIM_W-1:0] RST_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT   = 13'd480;
    localparam logic [NCH_W-1:0] RST_CHANNELS = 3'd3;

    localparam logic [DIM_W-1:0] MIN_DIM = 13'd3;

    // Frame geometry after clamping
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [NCH_W-1:0] chans;
    } t_geom;

    // Control word travelling from the address stage to the compute stage
    typedef struct packed {
        logic                valid;
        logic                upd;
        logic                emit;
        logic                zero;
        logic                last;
        logic [SAMPLE_W-1:0] sample;
    } t_s1_ctl;

    // One output word
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } t_result;

endpackage

// ===== rtl/sharpen_3x3_cross_filter_top.sv =====
// 3x3 cross sharpen filter (5*centre minus the four neighbors of the same
// channel, saturated to 0..255) over an interleaved 8-bit raster stream.
//
// Input channel: i_in_valid / o_in_ready carry one word: i_sample, or a
// flush request when i_drain is set. Output channel: o_out_valid /
// i_out_ready carry o_value and o_last (set on the final word of a frame).
// Frame geometry comes through the APB port: width at 0x0, height at 0x4,
// channel count at 0x8. A write to these restarts the frame; write only while idle.
//
// Throughput: one word per clock while the output queue has room. A
// result is formed from the registered compute-stage word, then goes through
// the output queue; in stream terms it trails its centre sample by one row
// plus one pixel. After the last sample of a frame, (width+1)*channels
// results are still owed; drain words (or the next frame's samples) flush
// them, all zero. Timing is set by the line store: one read at acceptance,
// the write-back in the next cycle. Output goes through a three-word queue; when the
// receiver stalls, o_in_ready drops once queued words plus the compute-stage word fill it.
// Reset loads 640x480x3, clears positions, window and queue; the line
// store is not cleared and needs no startup pass.
module sharpen_3x3_cross_filter_top
    import shp3x3_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_drain,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SAMPLE_W-1:0]   o_value,
    output logic                  o_last,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_CHANNELS);
    localparam int CH_W   = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam logic [DIM_W:0]   MAX_W_EXT = (DIM_W + 1)'(MAX_WIDTH);
    localparam logic [NCH_W-1:0] MAX_NCH   = NCH_W'(MAX_CHANNELS);

    // Configuration registers, stored as written
    logic [DIM_W-1:0] r_cfg_width;
    logic [DIM_W-1:0] r_cfg_height;
    logic [NCH_W-1:0] r_cfg_chans;

    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic        restart;
    t_geom       geom;

    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_chans  <= RST_CHANNELS;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WIDTH:    r_cfg_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT:   r_cfg_height <= pwdata[DIM_W-1:0];
                REG_CHANNELS: r_cfg_chans  <= pwdata[NCH_W-1:0];
                default: ;
            endcase
        end
    end

    // Any write to a known register restarts the frame
    always_comb begin
        case (cfg_idx)
            REG_WIDTH:    restart = cfg_wr;
            REG_HEIGHT:   restart = cfg_wr;
            REG_CHANNELS: restart = cfg_wr;
            default:      restart = 1'b0;
        endcase
    end

    always_comb begin
        case (cfg_idx)
            REG_WIDTH:    prdata = APB_DATA_W'(r_cfg_width);
            REG_HEIGHT:   prdata = APB_DATA_W'(r_cfg_height);
            REG_CHANNELS: prdata = APB_DATA_W'(r_cfg_chans);
            default:      prdata = '0;
        endcase
    end

    // Clamp the stored settings into the usable range
    always_comb begin
        if (r_cfg_width < MIN_DIM) begin
            geom.width = MIN_DIM;
        end else if ({1'b0, r_cfg_width} > MAX_W_EXT) begin
            geom.width = MAX_W_EXT[DIM_W-1:0];
        end else begin
            geom.width = r_cfg_width;
        end
        geom.height = (r_cfg_height < MIN_DIM) ? MIN_DIM : r_cfg_height;
        if (r_cfg_chans == '0) begin
            geom.chans = NCH_W'(1);
        end else if (r_cfg_chans > MAX_NCH) begin
            geom.chans = MAX_NCH;
        end else begin
            geom.chans = r_cfg_chans;
        end
    end

    // Datapath
    logic                  in_accept;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [2*SAMPLE_W-1:0] rd_data;
    t_s1_ctl               s1;
    logic [CH_W-1:0]       s1_ch;
    logic [ADDR_W-1:0]     s1_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [2*SAMPLE_W-1:0] wr_data;
    logic                  push;
    t_result               push_data;
    t_result               head;
    logic [CNT_W-1:0]      q_count;
    logic                  s1_emit;

    // Hold off input while the queue plus the word in flight would fill it
    assign s1_emit    = s1.valid && s1.emit;
    assign o_in_ready = ({1'b0, q_count} + (CNT_W + 1)'(s1_emit)) < (CNT_W + 1)'(OUT_DEPTH);
    assign in_accept  = i_in_valid && o_in_ready;

    shp3x3_ctrl #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_restart (restart),
        .i_accept  (in_accept),
        .i_sample  (i_sample),
        .i_drain   (i_drain),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_s1      (s1),
        .o_s1_ch   (s1_ch),
        .o_s1_addr (s1_addr)
    );

    // Upper and middle line stores share one entry per sample position
    shp3x3_line_mem #(
        .DEPTH  (MAX_WIDTH * MAX_CHANNELS),
        .DATA_W (2 * SAMPLE_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    shp3x3_core #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (s1),
        .i_ch      (s1_ch),
        .i_addr    (s1_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_push    (push),
        .o_result  (push_data)
    );

    shp3x3_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (head),
        .o_count (q_count)
    );

    assign o_value = head.value;
    assign o_last  = head.last;

endmodule

// ===== rtl/shp3x3_line_mem.sv =====
module shp3x3_line_mem
    import shp3x3_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_WIDTH * DEF_MAX_CHANNELS,
    parameter int DATA_W = 2 * SAMPLE_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_fwd_data;
    logic              r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Forward a write that lands on the entry being read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

    a_fwd_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && i_wr_en && i_rd_addr == i_wr_addr) |=> o_rd_data == $past(i_wr_data))
        else $error("line store read missed a same-cycle write");

endmodule

// ===== rtl/shp3x3_ctrl.sv =====
module shp3x3_ctrl
    import shp3x3_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  t_geom                                         i_geom,
    input  logic                                          i_restart,
    input  logic                                          i_accept,
    input  logic [SAMPLE_W-1:0]                           i_sample,
    input  logic                                          i_drain,
    output logic                                          o_rd_en,
    output logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0]     o_rd_addr,
    output t_s1_ctl                                       o_s1,
    output logic [(MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1)-1:0] o_s1_ch,
    output logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0]     o_s1_addr
);

    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_CHANNELS);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CH_W   = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
    localparam int FL_W   = $clog2((MAX_WIDTH + 1) * MAX_CHANNELS + 1);

    logic [COL_W-1:0]  r_col,   n_col;
    logic [DIM_W-1:0]  r_row,   n_row;
    logic [CH_W-1:0]   r_ch,    n_ch;
    logic [ADDR_W-1:0] r_k,     n_k;
    logic [FL_W-1:0]   r_flush, n_flush;
    t_s1_ctl           r_s1,    n_s1;
    logic [CH_W-1:0]   r_s1_ch;
    logic [ADDR_W-1:0] r_s1_addr;

    logic             last_ch;
    logic             last_col;
    logic             last_row;
    logic             pos_emit;
    logic             flush_take;
    logic [FL_W-1:0]  flush_load;

    always_comb begin
        last_ch    = (NCH_W'(r_ch) >= i_geom.chans - NCH_W'(1));
        last_col   = (DIM_W'(r_col) >= i_geom.width - DIM_W'(1));
        last_row   = (r_row >= i_geom.height - DIM_W'(1));
        pos_emit   = (r_row >= DIM_W'(2)) || (r_row == DIM_W'(1) && r_col != '0);
        flush_take = (i_drain || !pos_emit) && (r_flush != '0);
        flush_load = FL_W'((18'(i_geom.width) + 18'd1) * 18'(i_geom.chans));

        n_col   = r_col;
        n_row   = r_row;
        n_ch    = r_ch;
        n_k     = r_k;
        n_flush = flush_take ? r_flush - FL_W'(1) : r_flush;

        if (!i_drain) begin
            n_k = r_k + ADDR_W'(1);
            if (last_ch) begin
                n_ch = '0;
                if (last_col) begin
                    n_col = '0;
                    n_k   = '0;
                    if (last_row) begin
                        n_row   = '0;
                        n_flush = flush_load;
                    end else begin
                        n_row = r_row + DIM_W'(1);
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end else begin
                n_ch = r_ch + CH_W'(1);
            end
        end

        n_s1.valid  = i_accept;
        n_s1.upd    = !i_drain;
        n_s1.sample = i_sample;
        if (!i_drain && pos_emit) begin
            n_s1.emit = 1'b1;
            n_s1.zero = (r_col <= COL_W'(1)) || (r_row == DIM_W'(1));
            n_s1.last = 1'b0;
        end else begin
            n_s1.emit = flush_take;
            n_s1.zero = 1'b1;
            n_s1.last = flush_take && (r_flush == FL_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col   <= '0;
            r_row   <= '0;
            r_ch    <= '0;
            r_k     <= '0;
            r_flush <= '0;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_ch    <= n_ch;
            r_k     <= n_k;
            r_flush <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_ch   <= r_ch;
            r_s1_addr <= r_k;
        end
    end

    assign o_rd_en   = i_accept && !i_drain;
    assign o_rd_addr = r_k;
    assign o_s1      = r_s1;
    assign o_s1_ch   = r_s1_ch;
    assign o_s1_addr = r_s1_addr;

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NCH_W'(r_ch) < i_geom.chans)
        else $error("channel position beyond channel count");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DIM_W'(r_col) < i_geom.width)
        else $error("column position beyond row width");

endmodule

// ===== rtl/shp3x3_core.sv =====
module shp3x3_core
    import shp3x3_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  t_s1_ctl                                       i_s1,
    input  logic [(MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1)-1:0] i_ch,
    input  logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0]     i_addr,
    input  logic [2*SAMPLE_W-1:0]                         i_rd_data,
    output logic                                          o_wr_en,
    output logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0]     o_wr_addr,
    output logic [2*SAMPLE_W-1:0]                         o_wr_data,
    output logic                                          o_push,
    output t_result                                       o_result
);

    logic [SAMPLE_W-1:0] r_tap1  [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] r_tap2  [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] r_above [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] r_below [MAX_CHANNELS];

    logic [SAMPLE_W-1:0] up_now;
    logic [SAMPLE_W-1:0] mid_now;
    logic [SAMPLE_W-1:0] centre;
    logic [10:0]         pos_sum;
    logic [9:0]          neg_sum;
    logic [10:0]         diff;
    logic [SAMPLE_W-1:0] sharp;
    logic                upd;

    always_comb begin
        up_now  = i_rd_data[2*SAMPLE_W-1:SAMPLE_W];
        mid_now = i_rd_data[SAMPLE_W-1:0];
        centre  = r_tap2[i_ch];
        pos_sum = {1'b0, centre, 2'b00} + 11'(centre);
        neg_sum = 10'(r_tap1[i_ch]) + 10'(mid_now) + 10'(r_above[i_ch]) + 10'(r_below[i_ch]);
        diff    = pos_sum - 11'(neg_sum);
        if (pos_sum < 11'(neg_sum)) begin
            sharp = '0;
        end else if (diff > 11'd255) begin
            sharp = '1;
        end else begin
            sharp = diff[SAMPLE_W-1:0];
        end
        upd = i_s1.valid && i_s1.upd;
    end

    // Shift the channel window and the above/below delays
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_tap1[i]  <= '0;
                r_tap2[i]  <= '0;
                r_above[i] <= '0;
                r_below[i] <= '0;
            end
        end else if (upd) begin
            r_tap1[i_ch]  <= centre;
            r_tap2[i_ch]  <= mid_now;
            r_above[i_ch] <= up_now;
            r_below[i_ch] <= i_s1.sample;
        end
    end

    assign o_wr_en        = upd;
    assign o_wr_addr      = i_addr;
    assign o_wr_data      = {mid_now, i_s1.sample};
    assign o_push         = i_s1.valid && i_s1.emit;
    assign o_result.value = i_s1.zero ? '0 : sharp;
    assign o_result.last  = i_s1.last;

endmodule

// ===== rtl/shp3x3_out_fifo.sv =====
module shp3x3_out_fifo
    import shp3x3_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_result                    i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output t_result                    o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(do_pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CNT_W'(DEPTH)) || do_pop)
        else $error("output queue overflow");

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import shp3x3_pkg::*;

    // Line store depth at the default build: one entry per column and channel.
    localparam int LINE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
    // Address slot past the register list; writes there must change nothing.
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int ITEM_TARGET = 1900;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int WIDE_SAMPLES = 64;

    // Mirror of the filter: geometry registers, line stores, per-channel taps
    // and positions. Every accepted word advances it; sharpened words that the
    // block owes are queued in arrival order and matched against its output.
    class sharpen_calc;
        logic [DIM_W-1:0]    width_reg;
        logic [DIM_W-1:0]    height_reg;
        logic [NCH_W-1:0]    chans_reg;
        bit [SAMPLE_W-1:0]   upper_line[LINE_DEPTH];
        bit [SAMPLE_W-1:0]   middle_line[LINE_DEPTH];
        bit [SAMPLE_W-1:0]   taps[DEF_MAX_CHANNELS][3];
        bit [SAMPLE_W-1:0]   above_px[DEF_MAX_CHANNELS];
        bit [SAMPLE_W-1:0]   below_px[DEF_MAX_CHANNELS];
        int                  col_pos;
        int                  row_pos;
        int                  chan_pos;
        int                  owed;
        t_result             due_q[$];
        int                  errors;

        function void power_up();
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            chans_reg  = RST_CHANNELS;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            col_pos  = 0;
            row_pos  = 0;
            chan_pos = 0;
            owed     = 0;
        endfunction

        function int used_width();
            if (width_reg < MIN_DIM) return int'(MIN_DIM);
            if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function int used_height();
            if (height_reg < MIN_DIM) return int'(MIN_DIM);
            return int'(height_reg);
        endfunction

        function int used_channels();
            if (chans_reg < 1) return 1;
            if (chans_reg > DEF_MAX_CHANNELS) return DEF_MAX_CHANNELS;
            return int'(chans_reg);
        endfunction

        function void complain(string msg);
            errors++;
            if (errors <= 10) $display("%0t mismatch: %s", $time, msg);
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_WIDTH:    width_reg  = data[DIM_W-1:0];
                REG_HEIGHT:   height_reg = data[DIM_W-1:0];
                REG_CHANNELS: chans_reg  = data[NCH_W-1:0];
                default:      return;
            endcase
            restart();
        endfunction

        function void check_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_WIDTH: begin
                    if (data[DIM_W-1:0] !== width_reg)
                        complain($sformatf("width readback: expected %0d, got %0d",
                                           width_reg, data[DIM_W-1:0]));
                end
                REG_HEIGHT: begin
                    if (data[DIM_W-1:0] !== height_reg)
                        complain($sformatf("height readback: expected %0d, got %0d",
                                           height_reg, data[DIM_W-1:0]));
                end
                REG_CHANNELS: begin
                    if (data[NCH_W-1:0] !== chans_reg)
                        complain($sformatf("channels readback: expected %0d, got %0d",
                                           chans_reg, data[NCH_W-1:0]));
                end
                default: ;
            endcase
        endfunction

        // Advance on one accepted word; return how many result words it owes.
        function int push_word(logic [SAMPLE_W-1:0] smp, logic drn);
            int      w;
            int      h;
            int      nc;
            int      ch;
            int      k;
            int      acc;
            int      orow;
            int      ocol;
            bit      border;
            bit [SAMPLE_W-1:0] up_now;
            bit [SAMPLE_W-1:0] mid_now;
            bit [SAMPLE_W-1:0] sharp;
            t_result word;

            if (drn) begin
                if (owed == 0) return 0;
                owed--;
                word.value = '0;
                word.last  = (owed == 0);
                due_q.push_back(word);
                return 1;
            end

            w  = used_width();
            h  = used_height();
            nc = used_channels();
            ch = chan_pos;
            k  = col_pos * nc + ch;
            if (k >= LINE_DEPTH) k = 0;

            up_now = upper_line[k];
            mid_now = middle_line[k];
            upper_line[k] = mid_now;
            middle_line[k] = smp;

            taps[ch][0] = taps[ch][1];
            taps[ch][1] = taps[ch][2];
            taps[ch][2] = mid_now;

            acc = 5 * int'(taps[ch][1]) - int'(taps[ch][0]) - int'(taps[ch][2])
                - int'(above_px[ch]) - int'(below_px[ch]);
            if (acc < 0) sharp = '0;
            else if (acc > 255) sharp = '1;
            else sharp = acc[SAMPLE_W-1:0];
            above_px[ch] = up_now;
            below_px[ch] = smp;

            push_word = 0;
            if (row_pos >= 2 || (row_pos == 1 && col_pos >= 1)) begin
                orow = (col_pos >= 1) ? row_pos - 1 : row_pos - 2;
                ocol = (col_pos >= 1) ? col_pos - 1 : w - 1;
                border = (orow == 0) || (orow >= h - 1) || (ocol == 0) || (ocol >= w - 1);
                word.value = border ? '0 : sharp;
                word.last  = 1'b0;
                due_q.push_back(word);
                push_word = 1;
            end else if (owed > 0) begin
                owed--;
                word.value = '0;
                word.last  = (owed == 0);
                due_q.push_back(word);
                push_word = 1;
            end

            ch++;
            if (ch >= nc) begin
                ch = 0;
                col_pos++;
                if (col_pos >= w) begin
                    col_pos = 0;
                    row_pos++;
                    if (row_pos >= h) begin
                        row_pos = 0;
                        owed = (w + 1) * nc;
                    end
                end
            end
            chan_pos = ch;
        endfunction

        function void pop_compare(logic [SAMPLE_W-1:0] value, logic last);
            t_result want;
            if (due_q.size() == 0) begin
                complain($sformatf("unexpected word: value %0d, last %0b", value, last));
                return;
            end
            want = due_q.pop_front();
            if (value !== want.value)
                complain($sformatf("value: expected %0d, got %0d", want.value, value));
            if (last !== want.last)
                complain($sformatf("last: expected %0b, got %0b", want.last, last));
        endfunction

        function void close_out();
            if (due_q.size() != 0)
                complain($sformatf("%0d result words never arrived", due_q.size()));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [SAMPLE_W-1:0]   i_sample = '0;
    logic                  i_drain = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [SAMPLE_W-1:0]   o_value;
    logic                  o_last;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sharpen_calc calc = new();

    // Idling knobs, percent of cycles; changed by the stimulus as it goes.
    int idle_pct = 0;
    int stall_pct = 0;
    int items_done = 0;
    // Long receiver hold-off: raised by the stimulus, counted down below.
    bit hold_start = 1'b0;
    int hold_left = 0;
    int unsigned cycle_count = 0;

    sharpen_3x3_cross_filter_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .i_drain     (i_drain),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 i_clk = ~i_clk;

    // Give up if the run hangs; a correct run ends far below this.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off completely while a hold-off runs.
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check every result word taken at this edge against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            calc.pop_compare(o_value, o_last);
    end

    // Offer one word, after a random idle gap; return once it is taken.
    task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic drn);
        int n;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= smp;
        i_drain <= drn;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        n = calc.push_word(smp, drn);
        // drains that flush nothing are ignored by the block; do not count them
        if (!drn || n != 0) items_done++;
    endtask

    task automatic drain_words(input int count);
        for (int i = 0; i < count; i++) send_word(8'($urandom), 1'b1);
    endtask

    // Draw one sample: uniform, saturated extremes only, or a mix of both.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int mode);
        if (mode == 1 || (mode == 2 && $urandom_range(1) == 1))
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    // Send raster samples with occasional stray drains; start the receiver
    // hold-off after sample hold_at, if any.
    task automatic send_samples(input int count, input int mode, input int noise_pct,
                                input int hold_at);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < noise_pct) send_word(8'($urandom), 1'b1);
            send_word(pick_sample(mode), 1'b0);
            if (i == hold_at) hold_start = 1'b1;
        end
    endtask

    // Drop valid and wait until every owed word is out, then let the
    // pipeline settle in case a dropped drain is still in flight.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (calc.due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        calc.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic read_check(input logic [1:0] idx);
        logic [31:0] data;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        calc.check_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] data);
        apb_write(idx, data);
        read_check(idx);
    endtask

    // Rewrite some geometry registers: mostly small legal frames, sometimes
    // out of range, always with junk above the register bits.
    task automatic random_setup();
        logic [31:0] data;
        if ($urandom_range(99) < 60) begin
            data = $urandom;
            data[DIM_W-1:0] = DIM_W'(($urandom_range(99) < 85) ? $urandom_range(3, 10)
                                                                : $urandom_range(0, 2));
            set_reg(REG_WIDTH, data);
        end
        if ($urandom_range(99) < 60) begin
            data = $urandom;
            data[DIM_W-1:0] = DIM_W'(($urandom_range(99) < 85) ? $urandom_range(3, 7)
                                                                : $urandom_range(0, 2));
            set_reg(REG_HEIGHT, data);
        end
        if ($urandom_range(99) < 60) begin
            data = $urandom;
            data[NCH_W-1:0] = NCH_W'(($urandom_range(99) < 80) ? $urandom_range(1, 4)
                                                                : $urandom_range(4, 7) + 1);
            set_reg(REG_CHANNELS, data);
        end
    endtask

    initial begin
        int total;
        int cut;
        int pick;
        int mode;
        int frame_no;

        calc.power_up();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry should read back as 640x480, three channels.
        read_check(REG_WIDTH);
        read_check(REG_HEIGHT);
        read_check(REG_CHANNELS);

        // Directed: smallest frame, one channel, a single interior pixel.
        set_reg(REG_WIDTH, 3);
        set_reg(REG_HEIGHT, 3);
        set_reg(REG_CHANNELS, 1);
        // bright center on black: positive overflow, saturate high
        for (int i = 0; i < 9; i++) send_word((i == 4) ? 8'hFF : 8'h00, 1'b0);
        // next frame right away: its first samples flush the old frame's tail;
        // dark center on white saturates low
        for (int i = 0; i < 9; i++) send_word((i == 4) ? 8'h00 : 8'hFF, 1'b0);
        // flush the tail, then one drain with nothing owed
        drain_words(calc.owed + 1);

        // Width written as all ones and zero channels: stream part of the
        // first row, then let the next setup restart the frame.
        wait_idle();
        set_reg(REG_WIDTH, 32'hFFFF_FFFF);
        set_reg(REG_HEIGHT, 3);
        set_reg(REG_CHANNELS, 0);
        send_samples(WIDE_SAMPLES, 0, 0, -1);
        drain_words(calc.owed);

        // Random frames through the idling phases.
        items_done = 0;
        frame_no = 0;
        while (items_done < ITEM_TARGET) begin
            case (items_done * 4 / ITEM_TARGET)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            mode = $urandom_range(2);

            if (frame_no == 3) begin
                // Tallest height: run a few rows deep, then restart.
                wait_idle();
                set_reg(REG_WIDTH, $urandom_range(3, 6));
                set_reg(REG_HEIGHT, 32'h0000_1FFF);
                set_reg(REG_CHANNELS, $urandom_range(1, 4));
                send_samples(8 * calc.used_width() * calc.used_channels(), mode, 5, -1);
                wait_idle();
                set_reg(REG_HEIGHT, 5);
            end else begin
                if (frame_no == 0) begin
                    // below-range width and height, channels above range
                    wait_idle();
                    set_reg(REG_WIDTH, 0);
                    set_reg(REG_HEIGHT, 2);
                    set_reg(REG_CHANNELS, 7);
                end else if ($urandom_range(99) < 70) begin
                    wait_idle();
                    random_setup();
                end
                total = calc.used_width() * calc.used_height() * calc.used_channels();
                pick = (frame_no == 1) ? 99 : $urandom_range(99);
                if (pick < 10) begin
                    // broken frame: stop partway, restart by rewriting the width
                    send_samples($urandom_range(1, total - 1), mode, 5, -1);
                    wait_idle();
                    set_reg(REG_WIDTH, 32'(calc.width_reg));
                end else if (pick < 18) begin
                    // pause mid-frame, poke the unused slot, carry on unchanged
                    cut = $urandom_range(1, total - 1);
                    send_samples(cut, mode, 5, -1);
                    wait_idle();
                    apb_write(REG_SPARE, $urandom);
                    send_samples(total - cut, mode, 5, -1);
                    drain_words(calc.owed);
                end else begin
                    // whole frame; on the second one hold the receiver off
                    // halfway so the block backs up and stalls its input
                    send_samples(total, mode, 5, (frame_no == 1) ? total / 2 : -1);
                    pick = $urandom_range(99);
                    if (pick < 60) drain_words(calc.owed + $urandom_range(0, 2));
                    else if (pick < 85) drain_words($urandom_range(0, calc.owed));
                end
            end
            frame_no++;
        end

        idle_pct = 0;
        wait_idle();
        calc.close_out();
        if (calc.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
